### hw/rtl/lzd_pkg.sv
// shared types and constants of the lzss decompressor
package lzd_pkg;

    localparam int DICT_SIZE = 4096;
    localparam int AW        = $clog2(DICT_SIZE);
    localparam int LEN_W     = 24;
    localparam int LEFT_W    = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [AW-1:0]     WP_START      = AW'(4078);
    localparam logic [3:0]        FLAG_IDX_INIT = 4'd8;
    localparam logic [LEFT_W-1:0] REF_MIN_LEN   = LEFT_W'(3);

    localparam logic [ADDR_W-3:0] REG_DECODED_LENGTH = '0;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    typedef enum logic [2:0] {
        KIND_STATUS,
        KIND_FLAG,
        KIND_LOW,
        KIND_LITERAL,
        KIND_REF
    } t_kind;

    typedef struct packed {
        logic take;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  slot_free;
        logic  copy_last;
    } t_dp_status;

endpackage

### hw/rtl/lzd_if.sv
// stream channel interfaces of the lzss decompressor
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;
    logic       last_byte;

    modport source (output valid, output in_byte, output stream_start, output last_byte,
                    input ready);
    modport sink (input valid, input in_byte, input stream_start, input last_byte,
                  output ready);
endinterface

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_done;

    modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                    output stream_done, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
                  input stream_done, output ready);
endinterface

### hw/rtl/lzd_ctrl.sv
// controller state machine of the lzss decompressor
module lzd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lzd_pkg::t_dp_status i_status,
    output lzd_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_ready
);

    lzd_pkg::t_state r_state;
    lzd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzd_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.slot_free && i_status.kind == lzd_pkg::KIND_REF) begin
                    n_state = lzd_pkg::ST_COPY;
                end
            end
            lzd_pkg::ST_COPY: begin
                if (i_status.slot_free && i_status.copy_last) begin
                    n_state = lzd_pkg::ST_IDLE;
                end
            end
            default: n_state = lzd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lzd_pkg::ST_IDLE: begin
                o_in_ready = i_status.slot_free;
                o_cmd.take = i_in_valid && i_status.slot_free;
            end
            lzd_pkg::ST_COPY: begin
                o_cmd.emit = i_status.slot_free;
            end
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lzd_dp.sv
// datapath of the lzss decompressor: stream state, history memory, result register
module lzd_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lzd_pkg::t_dp_cmd                i_cmd,
    output lzd_pkg::t_dp_status             o_status,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_stream_start,
    input  logic                            i_last_byte,
    input  logic [lzd_pkg::LEN_W-1:0]       i_decoded_length,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_last_of_run,
    output logic                            o_stream_done
);

    localparam int AW = lzd_pkg::AW;
    localparam int LW = lzd_pkg::LEN_W;
    localparam int FW = lzd_pkg::LEFT_W;

    logic [7:0] mem [lzd_pkg::DICT_SIZE];

    logic [AW-1:0] r_wp;
    logic [7:0]    r_flags;
    logic [3:0]    r_fidx;
    logic [7:0]    r_plow;
    logic          r_pend;
    logic [LW-1:0] r_cnt;
    logic          r_ended;
    logic [AW:0]   r_fill;
    logic [AW-1:0] r_src;
    logic [FW-1:0] r_left;
    logic          r_done;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_obv;
    logic          r_olast;
    logic          r_odone;
    logic [7:0]    r_rd;
    logic          r_rd_ok;
    logic          r_byp;
    logic [7:0]    r_byp_d;

    logic          start;
    logic [AW-1:0] e_wp;
    logic [7:0]    e_flags;
    logic [3:0]    e_fidx;
    logic          e_pend;
    logic [LW-1:0] e_cnt;
    logic          e_ended;
    logic [AW:0]   e_fill;
    logic          ended0;
    logic [LW-1:0] rem;
    logic [FW-1:0] ref_len;
    logic [FW-1:0] ref_n;
    logic [AW-1:0] ref_pos;
    lzd_pkg::t_kind kind;
    logic          ended_after;
    logic          take;
    logic          emit;
    logic          lit;
    logic          load;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    cp_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_dist;
    logic          rd_ok;
    logic [AW:0]   fill_base;
    logic [AW:0]   fill_next;

    assign take  = i_cmd.take;
    assign emit  = i_cmd.emit;
    assign start = i_stream_start;

    // state as seen after an optional stream restart
    assign e_wp    = start ? lzd_pkg::WP_START      : r_wp;
    assign e_flags = start ? 8'd0                   : r_flags;
    assign e_fidx  = start ? lzd_pkg::FLAG_IDX_INIT : r_fidx;
    assign e_pend  = start ? 1'b0                   : r_pend;
    assign e_cnt   = start ? '0                     : r_cnt;
    assign e_ended = start ? 1'b0                   : r_ended;
    assign e_fill  = start ? '0                     : r_fill;

    assign ended0  = e_ended || (e_cnt >= i_decoded_length);
    assign rem     = i_decoded_length - e_cnt;
    assign ref_len = {1'b0, i_in_byte[3:0]} + lzd_pkg::REF_MIN_LEN;
    assign ref_n   = (rem <= LW'(ref_len)) ? rem[FW-1:0] : ref_len;
    assign ref_pos = {i_in_byte[7:4], r_plow};

    always_comb begin
        priority if (ended0) begin
            kind = lzd_pkg::KIND_STATUS;
        end else if (e_fidx[3]) begin
            kind = lzd_pkg::KIND_FLAG;
        end else if (e_pend) begin
            kind = lzd_pkg::KIND_REF;
        end else if (e_flags[e_fidx[2:0]]) begin
            kind = lzd_pkg::KIND_LITERAL;
        end else begin
            kind = lzd_pkg::KIND_LOW;
        end
    end

    always_comb begin
        unique case (kind)
            lzd_pkg::KIND_STATUS:  ended_after = 1'b1;
            lzd_pkg::KIND_LITERAL: ended_after = i_last_byte || (rem == LW'(1));
            lzd_pkg::KIND_REF:     ended_after = i_last_byte || (rem <= LW'(ref_len));
            default:               ended_after = i_last_byte;
        endcase
    end

    assign lit     = take && kind == lzd_pkg::KIND_LITERAL;
    assign load    = (take && kind != lzd_pkg::KIND_REF) || emit;
    assign cp_data = r_byp ? r_byp_d : (r_rd_ok ? r_rd : 8'd0);
    assign we      = lit || emit;
    assign waddr   = lit ? e_wp : r_wp;
    assign wdata   = lit ? i_in_byte : cp_data;

    always_comb begin
        priority if (take && kind == lzd_pkg::KIND_REF) begin
            rd_addr = ref_pos;
        end else if (emit) begin
            rd_addr = r_src + AW'(1);
        end else begin
            rd_addr = r_src;
        end
    end

    // entries not yet written since stream start read as zero
    assign rd_dist   = rd_addr - lzd_pkg::WP_START;
    assign rd_ok     = r_fill[AW] || (rd_dist < r_fill[AW-1:0]);
    assign fill_base = take ? e_fill : r_fill;
    assign fill_next = fill_base[AW] ? fill_base : fill_base + (AW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= rd_ok;
        r_byp   <= we && (waddr == rd_addr);
        r_byp_d <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= lzd_pkg::WP_START;
            r_flags <= 8'd0;
            r_fidx  <= lzd_pkg::FLAG_IDX_INIT;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_ended <= 1'b0;
            r_fill  <= '0;
            r_left  <= '0;
        end else if (take) begin
            if (start) begin
                r_wp    <= lzd_pkg::WP_START;
                r_pend  <= 1'b0;
                r_cnt   <= '0;
                r_fill  <= '0;
                // a flag byte loads the flag state itself
                if (kind != lzd_pkg::KIND_FLAG) begin
                    r_flags <= 8'd0;
                    r_fidx  <= lzd_pkg::FLAG_IDX_INIT;
                end
            end
            r_ended <= ended_after;
            unique case (kind)
                lzd_pkg::KIND_FLAG: begin
                    r_flags <= i_in_byte;
                    r_fidx  <= 4'd0;
                end
                lzd_pkg::KIND_LOW: begin
                    r_plow <= i_in_byte;
                    r_pend <= 1'b1;
                end
                lzd_pkg::KIND_LITERAL: begin
                    r_fidx <= e_fidx + 4'd1;
                    r_wp   <= e_wp + AW'(1);
                    r_cnt  <= e_cnt + LW'(1);
                    r_fill <= fill_next;
                end
                lzd_pkg::KIND_REF: begin
                    r_pend <= 1'b0;
                    r_fidx <= e_fidx + 4'd1;
                    r_src  <= ref_pos;
                    r_left <= ref_n;
                    r_done <= ended_after;
                end
                default: begin
                end
            endcase
        end else if (emit) begin
            r_wp   <= r_wp + AW'(1);
            r_cnt  <= r_cnt + LW'(1);
            r_fill <= fill_next;
            r_src  <= r_src + AW'(1);
            r_left <= r_left - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && kind != lzd_pkg::KIND_REF) begin
            r_ob    <= lit ? i_in_byte : 8'd0;
            r_obv   <= lit;
            r_olast <= 1'b1;
            r_odone <= ended_after;
        end else if (emit) begin
            r_ob    <= cp_data;
            r_obv   <= 1'b1;
            r_olast <= (r_left == FW'(1));
            r_odone <= r_done;
        end
    end

    assign o_status.kind      = kind;
    assign o_status.slot_free = !r_ov || i_out_ready;
    assign o_status.copy_last = (r_left == FW'(1));

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_byte_valid  = r_obv;
    assign o_last_of_run = r_olast;
    assign o_stream_done = r_odone;

endmodule

### hw/rtl/lzss_decompressor.sv
// top level of the lzss decompressor: channels, register port, controller and datapath
// a flag, literal or status result is valid in the cycle after its input transaction
// a reference's second byte moves the controller to its copy state, which then emits
// 1 byte per cycle through the result register while the output is not stalled
// (up to 18 bytes); input waits during a copy or while that register is full
// reset clears control state and the register; history needs no clearing pass
module lzss_decompressor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lzd_in_if.sink                        i_in,
    lzd_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzd_pkg::ADDR_W-1:0]    paddr,
    input  logic [lzd_pkg::DATA_W-1:0]    pwdata,
    output logic [lzd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [lzd_pkg::LEN_W-1:0] r_dlen;
    logic                      reg_hit;
    lzd_pkg::t_dp_cmd          cmd;
    lzd_pkg::t_dp_status       status;

    assign reg_hit = (paddr[lzd_pkg::ADDR_W-1:2] == lzd_pkg::REG_DECODED_LENGTH);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? lzd_pkg::DATA_W'(r_dlen) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_dlen <= pwdata[lzd_pkg::LEN_W-1:0];
        end
    end

    lzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready)
    );

    lzd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_byte        (i_in.in_byte),
        .i_stream_start   (i_in.stream_start),
        .i_last_byte      (i_in.last_byte),
        .i_decoded_length (r_dlen),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_out_byte       (o_out.out_byte),
        .o_byte_valid     (o_out.byte_valid),
        .o_last_of_run    (o_out.last_of_run),
        .o_stream_done    (o_out.stream_done)
    );

endmodule

### hw/rtl/lzd_checker.sv
// port checker of the lzss decompressor and its bind
module lzd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_last_of_run,
    input logic       i_stream_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_byte_valid) && $stable(i_last_of_run) && $stable(i_stream_done))
        else $error("result changed while stalled");

    a_in_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready)
        else $error("input taken while result register full");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_out_byte == 8'd0 && i_last_of_run)
        else $error("status result malformed");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_out_valid && i_byte_valid
            && (i_stream_done == $past(i_stream_done)))
        else $error("copy run broken");

endmodule

bind lzss_decompressor lzd_checker u_lzd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_last_of_run (o_out.last_of_run),
    .i_stream_done (o_out.stream_done)
);
